[sv/bpq_pkg.sv]
`default_nettype none
package bpq_pkg;

  localparam int KEY_W  = 32;
  localparam int VTX_W  = 20;
  localparam int LEVELS = 4;
  localparam int ENT_W  = KEY_W + VTX_W;

  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_EXTRACT = 2'd1,
    KIND_CLEAR   = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_EXTRACTED = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_DROPPED   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SCAN_NORMAL = 2'd0,
    SCAN_LOW    = 2'd1,
    SCAN_FINAL  = 2'd2
  } scan_mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS,
    S_SC3,
    S_POP,
    S_UP,
    S_LVSCAN,
    S_RD_CHK,
    S_RD_DATA,
    S_RD_PUSH
  } state_t;

endpackage
`default_nettype wire

[sv/bpq_meta.sv]
`default_nettype none
module bpq_meta #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int HW    = 6,
  parameter int FW    = 7
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          clr,
  input  wire logic [AW-1:0] raddr,
  output logic      [HW-1:0] rhead,
  output logic      [FW-1:0] rfill,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [HW-1:0] whead,
  input  wire logic [FW-1:0] wfill
);

  logic [HW-1:0]    mem_head [DEPTH];
  logic [FW-1:0]    mem_fill [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [HW-1:0]    head_q;
  logic [FW-1:0]    fill_q;
  logic             valid_q;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_head[waddr] <= whead;
      mem_fill[waddr] <= wfill;
    end
  end

  // track written entries; unwritten ones read as zero
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (we) valid[waddr] <= 1'b1;
      valid_q <= valid[raddr];
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    head_q <= mem_head[raddr];
    fill_q <= mem_fill[raddr];
  end

  assign rhead = valid_q ? head_q : '0;
  assign rfill = valid_q ? fill_q : '0;

endmodule
`default_nettype wire

[sv/bpq_store.sv]
`default_nettype none
module bpq_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 52
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata
);

  logic [DW-1:0] mem [DEPTH];

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/four_level_bucket_priority_queue_core.sv]
`default_nettype none
// Four-level radix bucket priority queue. A request is taken when start is high
// and busy is low; its single result shows for one cycle with done high and
// cannot be held off. Bucket heads and fills sit in one memory and entries in a
// second, both with a registered read, and one sequencer walks them.
// An insert reads its bucket's head and fill and then writes the entry; a clear,
// an unused kind and a queue-empty extract answer straight from idle. A direct
// extract examines level-3 buckets in turn up to the hit and hands out its front
// entry. An extract that refills level 3 first picks the level, then finds its
// next nonempty bucket, moves each entry downward by checking, reading and
// pushing it, and finishes each level in turn.
// No clearing pass after reset.
module four_level_bucket_priority_queue_core
  import bpq_pkg::*;
#(
  parameter int RADIX_BITS      = 4,
  parameter int BUCKET_CAPACITY = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       kind,
  input  wire logic [VTX_W-1:0] vertex,
  input  wire logic [KEY_W-1:0] key,
  output logic                  done,
  output logic [1:0]            status,
  output logic [VTX_W-1:0]      out_vertex,
  output logic [KEY_W-1:0]      out_key,
  output logic                  is_empty
);

  localparam int NB   = 1 << RADIX_BITS;
  localparam int AB   = RADIX_BITS + 1;
  localparam int BW   = RADIX_BITS + 2;
  localparam int HW   = $clog2(BUCKET_CAPACITY);
  localparam int FW   = $clog2(BUCKET_CAPACITY + 1);
  localparam int SD   = LEVELS * NB * BUCKET_CAPACITY;
  localparam int SAW  = $clog2(SD);
  localparam int LCW  = $clog2(NB * BUCKET_CAPACITY + 1);
  localparam int TW   = $clog2(SD + 1);

  function automatic logic [RADIX_BITS-1:0] dig(input logic [KEY_W-1:0] k,
                                                input logic [1:0] l);
    logic [KEY_W-1:0] s;
    s = k >> ((3 - int'(l)) * RADIX_BITS);
    return s[RADIX_BITS-1:0];
  endfunction

  function automatic logic [SAW-1:0] saddr(input logic [BW-1:0] b,
                                           input logic [HW-1:0] p);
    return SAW'(int'(b) * BUCKET_CAPACITY + int'(p));
  endfunction

  function automatic logic [HW-1:0] hinc(input logic [HW-1:0] h);
    return (int'(h) == BUCKET_CAPACITY - 1) ? '0 : h + 1'b1;
  endfunction

  function automatic logic [HW-1:0] tailpos(input logic [HW-1:0] h,
                                            input logic [FW-1:0] f);
    logic [FW:0] s;
    s = (FW + 1)'(h) + (FW + 1)'(f);
    if (int'(s) >= BUCKET_CAPACITY) s = s - (FW + 1)'(BUCKET_CAPACITY);
    return s[HW-1:0];
  endfunction

  state_t          state, state_next;
  scan_mode_t      mode, mode_next;
  logic [KEY_W-1:0] key_q, key_q_next;
  logic [VTX_W-1:0] vtx_q, vtx_q_next;
  logic [AB-1:0]   act [LEVELS];
  logic [AB-1:0]   act_next [LEVELS];
  logic [LCW-1:0]  lc [LEVELS];
  logic [LCW-1:0]  lc_next [LEVELS];
  logic [TW-1:0]   total, total_next;
  logic [1:0]      lvl, lvl_next;
  logic [RADIX_BITS-1:0] src, src_next;
  logic [RADIX_BITS-1:0] dq, dq_next;
  logic [AB-1:0]   cnt, cnt_next;
  logic            done_next;
  logic [1:0]      status_next;
  logic [VTX_W-1:0] out_vertex_next;
  logic [KEY_W-1:0] out_key_next;
  logic            is_empty_next;

  logic            meta_clr;
  logic [BW-1:0]   meta_raddr, meta_waddr;
  logic [HW-1:0]   meta_rhead, meta_whead;
  logic [FW-1:0]   meta_rfill, meta_wfill;
  logic            meta_we;
  logic [SAW-1:0]  st_raddr, st_waddr;
  logic [ENT_W-1:0] st_rdata, st_wdata;
  logic            st_we;

  bpq_meta #(.DEPTH(LEVELS * NB), .AW(BW), .HW(HW), .FW(FW)) u_meta (
    .clk(clk), .rst(rst), .clr(meta_clr),
    .raddr(meta_raddr), .rhead(meta_rhead), .rfill(meta_rfill),
    .we(meta_we), .waddr(meta_waddr), .whead(meta_whead), .wfill(meta_wfill)
  );

  bpq_store #(.DEPTH(SD), .AW(SAW), .DW(ENT_W)) u_store (
    .clk(clk), .raddr(st_raddr), .rdata(st_rdata),
    .we(st_we), .waddr(st_waddr), .wdata(st_wdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= SCAN_NORMAL;
      total <= '0;
      done  <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        act[i] <= '0;
        lc[i]  <= '0;
      end
    end else begin
      state <= state_next;
      mode  <= mode_next;
      total <= total_next;
      done  <= done_next;
      for (int i = 0; i < LEVELS; i++) begin
        act[i] <= act_next[i];
        lc[i]  <= lc_next[i];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_q      <= key_q_next;
    vtx_q      <= vtx_q_next;
    lvl        <= lvl_next;
    src        <= src_next;
    dq         <= dq_next;
    cnt        <= cnt_next;
    status     <= status_next;
    out_vertex <= out_vertex_next;
    out_key    <= out_key_next;
    is_empty   <= is_empty_next;
  end

  assign busy = (state != S_IDLE);

  // sequencer
  always_comb begin
    logic [RADIX_BITS-1:0] d0, d1, d2, d3, dn;
    logic [AB-1:0] na;
    state_next      = state;
    mode_next       = mode;
    key_q_next      = key_q;
    vtx_q_next      = vtx_q;
    total_next      = total;
    lvl_next        = lvl;
    src_next        = src;
    dq_next         = dq;
    cnt_next        = cnt;
    done_next       = 1'b0;
    status_next     = status;
    out_vertex_next = out_vertex;
    out_key_next    = out_key;
    is_empty_next   = is_empty;
    for (int i = 0; i < LEVELS; i++) begin
      act_next[i] = act[i];
      lc_next[i]  = lc[i];
    end
    meta_clr   = 1'b0;
    meta_raddr = '0;
    meta_we    = 1'b0;
    meta_waddr = '0;
    meta_whead = '0;
    meta_wfill = '0;
    st_raddr   = '0;
    st_we      = 1'b0;
    st_waddr   = '0;
    st_wdata   = {key_q, vtx_q};
    d0 = dig(key, 2'd0);
    d1 = dig(key, 2'd1);
    d2 = dig(key, 2'd2);
    d3 = dig(key, 2'd3);
    dn = dig(st_rdata[ENT_W-1:VTX_W], lvl + 2'd1);
    na = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          key_q_next = key;
          vtx_q_next = vertex;
          out_vertex_next = '0;
          out_key_next    = '0;
          status_next     = ST_DONE;
          case (kind)
            KIND_INSERT: begin
              // pick the first of levels 0-2 whose digit differs from act, or 2 if d3 < act[3]; else 3
              if (AB'(d0) != act[0]) begin
                lvl_next = 2'd0; dq_next = d0;
              end else if (AB'(d1) != act[1]) begin
                lvl_next = 2'd1; dq_next = d1;
              end else if (AB'(d2) != act[2] || AB'(d3) < act[3]) begin
                lvl_next = 2'd2; dq_next = d2;
              end else begin
                lvl_next = 2'd3; dq_next = d3;
              end
              meta_raddr = {lvl_next, dq_next};
              state_next = S_INS;
            end
            KIND_EXTRACT: begin
              if (total == '0) begin
                status_next   = ST_EMPTY;
                is_empty_next = 1'b1;
                done_next     = 1'b1;
              end else if (int'(act[3]) < NB) begin
                meta_raddr = {2'd3, act[3][RADIX_BITS-1:0]};
                mode_next  = SCAN_NORMAL;
                state_next = S_SC3;
              end else begin
                state_next = S_UP;
              end
            end
            KIND_CLEAR: begin
              meta_clr   = 1'b1;
              total_next = '0;
              for (int i = 0; i < LEVELS; i++) begin
                act_next[i] = '0;
                lc_next[i]  = '0;
              end
              is_empty_next = 1'b1;
              done_next     = 1'b1;
            end
            default: begin
              is_empty_next = (total == '0);
              done_next     = 1'b1;
            end
          endcase
        end
      end

      S_INS: begin
        // push at the tail unless the bucket is full
        if (int'(meta_rfill) >= BUCKET_CAPACITY) begin
          status_next   = ST_DROPPED;
          is_empty_next = (total == '0);
        end else begin
          st_we      = 1'b1;
          st_waddr   = saddr({lvl, dq}, tailpos(meta_rhead, meta_rfill));
          meta_we    = 1'b1;
          meta_waddr = {lvl, dq};
          meta_whead = meta_rhead;
          meta_wfill = meta_rfill + 1'b1;
          lc_next[lvl] = lc[lvl] + 1'b1;
          total_next   = total + 1'b1;
          is_empty_next = 1'b0;
        end
        done_next  = 1'b1;
        state_next = S_IDLE;
      end

      S_SC3: begin
        // walk level 3 for a nonempty bucket
        if (meta_rfill != '0) begin
          meta_we    = 1'b1;
          meta_waddr = {2'd3, act[3][RADIX_BITS-1:0]};
          meta_whead = hinc(meta_rhead);
          meta_wfill = meta_rfill - 1'b1;
          st_raddr   = saddr({2'd3, act[3][RADIX_BITS-1:0]}, meta_rhead);
          state_next = S_POP;
        end else if (mode == SCAN_FINAL) begin
          status_next   = ST_EMPTY;
          is_empty_next = (total == '0);
          done_next     = 1'b1;
          state_next    = S_IDLE;
        end else if (int'(act[3]) + 1 < NB) begin
          act_next[3] = act[3] + 1'b1;
          meta_raddr  = {2'd3, act_next[3][RADIX_BITS-1:0]};
        end else begin
          act_next[3] = AB'(NB);
          if (mode == SCAN_LOW) begin
            status_next   = ST_EMPTY;
            is_empty_next = (total == '0);
            done_next     = 1'b1;
            state_next    = S_IDLE;
          end else begin
            state_next = S_UP;
          end
        end
      end

      S_POP: begin
        // hand out the front entry
        lc_next[3]      = lc[3] - 1'b1;
        total_next      = total - 1'b1;
        status_next     = ST_EXTRACTED;
        out_key_next    = st_rdata[ENT_W-1:VTX_W];
        out_vertex_next = st_rdata[VTX_W-1:0];
        is_empty_next   = (total_next == '0);
        done_next       = 1'b1;
        state_next      = S_IDLE;
      end

      S_UP: begin
        // find the level nearest 3 among 2 to 0 that holds entries; if none, rescan level 3 from bucket 0
        if (lc[2] != '0 || lc[1] != '0 || lc[0] != '0) begin
          if (lc[2] != '0)      lvl_next = 2'd2;
          else if (lc[1] != '0) lvl_next = 2'd1;
          else                  lvl_next = 2'd0;
          src_next   = act[lvl_next][RADIX_BITS-1:0];
          cnt_next   = '0;
          meta_raddr = {lvl_next, src_next};
          state_next = S_LVSCAN;
        end else begin
          act_next[3] = '0;
          meta_raddr  = '0;
          meta_raddr[BW-1:BW-2] = 2'd3;
          mode_next   = SCAN_LOW;
          state_next  = S_SC3;
        end
      end

      S_LVSCAN: begin
        // advance the level circularly to a nonempty bucket
        if (meta_rfill == '0 && int'(cnt) + 1 < NB) begin
          src_next   = src + 1'b1;
          cnt_next   = cnt + 1'b1;
          meta_raddr = {lvl, src_next};
        end else begin
          if (meta_rfill == '0) src_next = src + 1'b1;
          act_next[lvl]        = AB'(src_next);
          act_next[lvl + 2'd1] = AB'(NB);
          meta_raddr = {lvl, src_next};
          state_next = S_RD_CHK;
        end
      end

      S_RD_CHK: begin
        if (meta_rfill != '0) begin
          // pop from the source bucket
          meta_we    = 1'b1;
          meta_waddr = {lvl, src};
          meta_whead = hinc(meta_rhead);
          meta_wfill = meta_rfill - 1'b1;
          st_raddr   = saddr({lvl, src}, meta_rhead);
          lc_next[lvl] = lc[lvl] - 1'b1;
          state_next = S_RD_DATA;
        end else begin
          // finish this level and drop to the next
          na = (int'(act[lvl + 2'd1]) >= NB) ? '0 : act[lvl + 2'd1];
          act_next[lvl + 2'd1] = na;
          if (lvl == 2'd2) begin
            meta_raddr = {2'd3, na[RADIX_BITS-1:0]};
            mode_next  = SCAN_FINAL;
            state_next = S_SC3;
          end else begin
            lvl_next = lvl + 2'd1;
            src_next = na[RADIX_BITS-1:0];
            act_next[lvl + 2'd2] = AB'(NB);
            meta_raddr = {lvl_next, src_next};
          end
        end
      end

      S_RD_DATA: begin
        // hold the moved entry and fetch its target bucket
        key_q_next = st_rdata[ENT_W-1:VTX_W];
        vtx_q_next = st_rdata[VTX_W-1:0];
        dq_next    = dn;
        meta_raddr = {lvl + 2'd1, dn};
        state_next = S_RD_PUSH;
      end

      S_RD_PUSH: begin
        if (int'(meta_rfill) >= BUCKET_CAPACITY) begin
          total_next = total - 1'b1;
        end else begin
          st_we      = 1'b1;
          st_waddr   = saddr({lvl + 2'd1, dq}, tailpos(meta_rhead, meta_rfill));
          meta_we    = 1'b1;
          meta_waddr = {lvl + 2'd1, dq};
          meta_whead = meta_rhead;
          meta_wfill = meta_rfill + 1'b1;
          lc_next[lvl + 2'd1] = lc[lvl + 2'd1] + 1'b1;
        end
        if (AB'(dq) < act[lvl + 2'd1]) act_next[lvl + 2'd1] = AB'(dq);
        meta_raddr = {lvl, src};
        state_next = S_RD_CHK;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[sv/bpq_checker.sv]
`default_nettype none
module bpq_checker
  import bpq_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             done,
  input wire logic [1:0]       status,
  input wire logic [VTX_W-1:0] out_vertex,
  input wire logic [KEY_W-1:0] out_key,
  input wire logic             is_empty
);

  // a result only shows once the request has retired
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while busy");

  // non-extract results carry no entry
  a_zero_entry: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_EXTRACTED) |-> (out_vertex == '0 && out_key == '0))
    else $error("entry fields set without extract");

  // an accepted request either works or answers at once
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done)) else $error("request lost");

  // reset leaves the block quiet
  a_reset: assert property (@(posedge clk)
    rst |=> (!busy && !done)) else $error("not idle after reset");

  // an extract that takes the last entry reports from idle
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EXTRACTED && is_empty) |-> !busy)
    else $error("bad extract report");

endmodule

bind four_level_bucket_priority_queue_core bpq_checker u_bpq_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .out_vertex(out_vertex), .out_key(out_key),
  .is_empty(is_empty)
);
`default_nettype wire

[tb/tb_four_level_bucket_priority_queue_core.sv]
`timescale 1ns / 100ps
module tb_four_level_bucket_priority_queue_core;
  import bpq_pkg::*;

  localparam int RB     = 4;
  localparam int NBK    = 1 << RB;
  localparam int CAP    = 64;
  localparam int NLV    = 4;

  typedef struct {
    status_t          status;
    logic [VTX_W-1:0] vtx;
    logic [KEY_W-1:0] key;
    logic             empty;
  } qresult_t;

  // Bucket queue predictor plus the queue of pending results
  class bucket_queue_scoreboard;
    logic [KEY_W-1:0] ent_key [NLV*NBK*CAP];
    logic [VTX_W-1:0] ent_vtx [NLV*NBK*CAP];
    int unsigned head [NLV*NBK];
    int unsigned fill [NLV*NBK];
    int unsigned act [NLV];
    int unsigned lcount [NLV];
    int unsigned total;
    logic [KEY_W-1:0] last_key;
    qresult_t pending_q [$];
    int errors;

    function void wipe();
      foreach (head[i]) begin
        head[i] = 0;
        fill[i] = 0;
      end
      foreach (act[i]) begin
        act[i] = 0;
        lcount[i] = 0;
      end
      total = 0;
    endfunction

    function new();
      wipe();
      errors = 0;
      last_key = '0;
    endfunction

    function int unsigned digit(logic [KEY_W-1:0] k, int unsigned lv);
      return (k >> ((3 - lv) * RB)) & (NBK - 1);
    endfunction

    function bit push(int unsigned lv, int unsigned d, logic [KEY_W-1:0] k,
                      logic [VTX_W-1:0] v);
      int unsigned b;
      int unsigned pos;
      b = lv * NBK + d;
      if (fill[b] >= CAP) return 0;
      pos = (head[b] + fill[b]) % CAP;
      ent_key[b*CAP+pos] = k;
      ent_vtx[b*CAP+pos] = v;
      fill[b]++;
      return 1;
    endfunction

    function void pop(int unsigned lv, int unsigned d, output logic [KEY_W-1:0] k,
                      output logic [VTX_W-1:0] v);
      int unsigned b;
      b = lv * NBK + d;
      k = ent_key[b*CAP+head[b]];
      v = ent_vtx[b*CAP+head[b]];
      head[b] = (head[b] + 1) % CAP;
      fill[b]--;
    endfunction

    function int unsigned fill_at(int unsigned lv, int unsigned d);
      return fill[lv*NBK + (d & (NBK-1))];
    endfunction

    // Refill level 3 from the highest nonempty level
    function void refill();
      int lv;
      int unsigned b, n, src, d;
      logic [KEY_W-1:0] k;
      logic [VTX_W-1:0] v;
      while (act[3] < NBK && fill_at(3, act[3]) == 0) act[3]++;
      if (act[3] < NBK) return;
      lv = 2;
      while (lv >= 0 && lcount[lv] == 0) lv--;
      if (lv < 0) begin
        b = 0;
        while (b < NBK && fill_at(3, b) == 0) b++;
        act[3] = b;
        return;
      end
      b = act[lv] & (NBK-1);
      for (n = 0; n < NBK && fill_at(lv, b) == 0; n++) b = (b + 1) & (NBK-1);
      act[lv] = b;
      for (int i = lv; i < 3; i++) begin
        src = act[i] & (NBK-1);
        act[i+1] = NBK;
        while (fill_at(i, src) > 0) begin
          pop(i, src, k, v);
          d = digit(k, i + 1);
          lcount[i]--;
          if (push(i + 1, d, k, v)) lcount[i+1]++;
          else total--;
          if (d < act[i+1]) act[i+1] = d;
        end
        if (act[i+1] >= NBK) act[i+1] = 0;
      end
    endfunction

    // Note an accepted request and queue its expected result
    function void note(kind_t kd, logic [VTX_W-1:0] v, logic [KEY_W-1:0] k);
      qresult_t r;
      int unsigned lv, d, d3;
      r.status = ST_DONE;
      r.vtx = '0;
      r.key = '0;
      case (kd)
        KIND_INSERT: begin
          d = digit(k, 0);
          if (d != act[0]) lv = 0;
          else begin
            d = digit(k, 1);
            if (d != act[1]) lv = 1;
            else begin
              d = digit(k, 2);
              d3 = digit(k, 3);
              if (d != act[2] || d3 < act[3]) lv = 2;
              else begin
                lv = 3;
                d = d3;
              end
            end
          end
          if (push(lv, d, k, v)) begin
            lcount[lv]++;
            total++;
          end else r.status = ST_DROPPED;
        end
        KIND_EXTRACT: begin
          if (total == 0) r.status = ST_EMPTY;
          else begin
            refill();
            if (act[3] < NBK && fill_at(3, act[3]) > 0) begin
              pop(3, act[3], r.key, r.vtx);
              lcount[3]--;
              total--;
              r.status = ST_EXTRACTED;
              last_key = r.key;
            end else r.status = ST_EMPTY;
          end
        end
        KIND_CLEAR: wipe();
        default: ;
      endcase
      r.empty = (total == 0);
      pending_q.push_back(r);
    endfunction

    // Compare one result with the oldest expectation
    function void check(logic [1:0] st, logic [VTX_W-1:0] v, logic [KEY_W-1:0] k,
                        logic e);
      qresult_t x;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result status %0d", $time, st);
        errors++;
        return;
      end
      x = pending_q.pop_front();
      if (st !== x.status) begin
        $display("%0t: status expected %0d actual %0d", $time, x.status, st);
        errors++;
      end
      if (v !== x.vtx) begin
        $display("%0t: out_vertex expected %h actual %h", $time, x.vtx, v);
        errors++;
      end
      if (k !== x.key) begin
        $display("%0t: out_key expected %h actual %h", $time, x.key, k);
        errors++;
      end
      if (e !== x.empty) begin
        $display("%0t: is_empty expected %0b actual %0b", $time, x.empty, e);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [1:0]       kind;
  logic [VTX_W-1:0] vertex;
  logic [KEY_W-1:0] key;
  logic             done;
  logic [1:0]       status;
  logic [VTX_W-1:0] out_vertex;
  logic [KEY_W-1:0] out_key;
  logic             is_empty;

  bucket_queue_scoreboard sb = new();
  bit steady;

  four_level_bucket_priority_queue_core #(
    .RADIX_BITS(RB),
    .BUCKET_CAPACITY(CAP)
  ) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .vertex(vertex), .key(key), .done(done), .status(status),
    .out_vertex(out_vertex), .out_key(out_key), .is_empty(is_empty)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Note accepted requests and check results
  always @(posedge clk) begin
    if (!rst && start && !busy) sb.note(kind_t'(kind), vertex, key);
    if (!rst && done) sb.check(status, out_vertex, out_key, is_empty);
  end

  // Issue one request, idling first at random outside the steady phase
  task automatic send_request(kind_t kd, logic [VTX_W-1:0] v, logic [KEY_W-1:0] k);
    int gap;
    if (!steady && $urandom_range(99) < 21) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    kind   <= kd;
    vertex <= v;
    key    <= k;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
  endtask

  // Key near the current minimum, varying the low digits
  function automatic logic [KEY_W-1:0] near_key();
    int sh;
    sh = $urandom_range(1, 16);
    return sb.last_key + ($urandom() & ((32'd1 << sh) - 1));
  endfunction

  initial begin
    int pick, burst, wait_n;
    logic [KEY_W-1:0] bk;
    start  <= 1'b0;
    kind   <= KIND_INSERT;
    vertex <= '0;
    key    <= '0;
    rst    <= 1'b1;
    steady = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty extract, extremes, unused kind, clear
    send_request(KIND_EXTRACT, '0, '0);
    send_request(KIND_INSERT, '0, '0);
    send_request(KIND_INSERT, '1, '1);
    send_request(KIND_INSERT, 20'h5a5a5, 32'h0000_1234);
    send_request(KIND_INSERT, 20'h0f0f0, 32'h0001_0000);
    send_request(KIND_INSERT, 20'h12345, 32'h0000_0010);
    send_request(KIND_NONE, '1, '1);
    for (int i = 0; i < 7; i++) send_request(KIND_EXTRACT, '0, '0);
    send_request(KIND_INSERT, 20'h00001, 32'h0000_0003);
    send_request(KIND_INSERT, 20'h00002, 32'h0000_8000);
    send_request(KIND_CLEAR, '0, '0);
    send_request(KIND_EXTRACT, '0, '0);

    // Random: mostly monotone inserts and extracts, some bursts and noise
    for (int n = 0; n < 1300; n++) begin
      steady = (n >= 300 && n < 550);
      if (n == 700) begin
        start <= 1'b0;
        wait_n = 0;
        do begin
          @(posedge clk);
          wait_n++;
        end while (sb.pending_q.size() != 0 && wait_n < 200000);
      end
      pick = $urandom_range(99);
      if (pick < 45) send_request(KIND_INSERT, VTX_W'($urandom()), near_key());
      else if (pick < 52) send_request(KIND_INSERT, VTX_W'($urandom()), $urandom());
      else if (pick < 54) begin
        // Fill one bucket near or past its capacity with a run of equal keys
        bk = near_key();
        burst = $urandom_range(62, 68);
        for (int b = 0; b < burst; b++) send_request(KIND_INSERT, VTX_W'($urandom()), bk);
        n += burst;
      end else if (pick < 95) send_request(KIND_EXTRACT, VTX_W'($urandom()), $urandom());
      else if (pick < 97) send_request(KIND_CLEAR, VTX_W'($urandom()), $urandom());
      else send_request(KIND_NONE, VTX_W'($urandom()), $urandom());
    end
    start <= 1'b0;

    // Drain
    wait_n = 0;
    do begin
      @(posedge clk);
      wait_n++;
    end while (sb.pending_q.size() != 0 && wait_n < 500000);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("tb_four_level_bucket_priority_queue_core: done, clean");
    else
      $display("tb_four_level_bucket_priority_queue_core: done, errors");
    $finish;
  end

  // Hard stop on a hang
  initial begin
    #40000000;
    $display("tb_four_level_bucket_priority_queue_core: done, errors");
    $finish;
  end

endmodule
